FILE: sv/pab_pkg.sv
package pab_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_BLEND_MODE  = 3'd0;
    localparam logic [2:0] REG_TINT_RED    = 3'd1;
    localparam logic [2:0] REG_TINT_GREEN  = 3'd2;
    localparam logic [2:0] REG_TINT_BLUE   = 3'd3;
    localparam logic [2:0] REG_LAYER_ALPHA = 3'd4;

    // blend mode codes, 5..7 pass the destination through
    localparam logic [2:0] MODE_PREMULT        = 3'd0;
    localparam logic [2:0] MODE_PREMULT_OPAQUE = 3'd1;
    localparam logic [2:0] MODE_TINT           = 3'd2;
    localparam logic [2:0] MODE_TINT_OPAQUE    = 3'd3;
    localparam logic [2:0] MODE_STRAIGHT       = 3'd4;

    // lane order inside the operand words
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [8:0] WEIGHT_ONE = 9'd256;
    localparam logic [7:0] ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
        logic       last_in;
    } in_pix_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       last_out;
    } out_pix_t;

    typedef struct packed {
        logic [2:0] blend_mode;
        logic [7:0] tint_red;
        logic [7:0] tint_green;
        logic [7:0] tint_blue;
        logic [8:0] layer_alpha;
    } cfg_t;

    // one channel: base + floor(wt * x / 256)
    typedef struct packed {
        logic [7:0]        base;
        logic [8:0]        wt;
        logic signed [8:0] x;
    } lane_t;

    typedef struct packed {
        lane_t [3:0] lane;
        logic        last;
    } ops_t;

    // one channel after the multiply, product kept modulo 2^16
    typedef struct packed {
        logic [7:0]  base;
        logic [15:0] prod;
    } prod_lane_t;

    typedef struct packed {
        prod_lane_t [3:0] lane;
        logic             last;
    } prods_t;

endpackage

FILE: sv/pixel_alpha_blender_top.sv
// throughput: one pixel per cycle while m_ready does not stall the four-stage pipeline
// (weight, operand select, multiply, add and output register)
// reset: synchronous active-low aresetn empties all stages and loads
// blend_mode 0, tint colour 0 and layer_alpha 256
module pixel_alpha_blender_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pab_pkg::in_pix_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pab_pkg::out_pix_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [8:0]        cfg_data
);
    import pab_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   ops_valid;
    logic   ops_ready;
    ops_t   ops;
    logic   prods_valid;
    logic   prods_ready;
    prods_t prods;

    assign cfg_ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BLEND_MODE:  cfg_next.blend_mode  = cfg_data[2:0];
                REG_TINT_RED:    cfg_next.tint_red    = cfg_data[7:0];
                REG_TINT_GREEN:  cfg_next.tint_green  = cfg_data[7:0];
                REG_TINT_BLUE:   cfg_next.tint_blue   = cfg_data[7:0];
                REG_LAYER_ALPHA: cfg_next.layer_alpha = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blend_mode  <= MODE_PREMULT;
            cfg_reg.tint_red    <= '0;
            cfg_reg.tint_green  <= '0;
            cfg_reg.tint_blue   <= '0;
            cfg_reg.layer_alpha <= WEIGHT_ONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pab_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pix    (s_data),
        .out_valid (ops_valid),
        .out_ready (ops_ready),
        .out_ops   (ops)
    );

    pab_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ops_valid),
        .in_ready  (ops_ready),
        .in_ops    (ops),
        .out_valid (prods_valid),
        .out_ready (prods_ready),
        .out_prods (prods)
    );

    pab_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prods_valid),
        .in_ready  (prods_ready),
        .in_prods  (prods),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pix   (m_data)
    );

endmodule

FILE: sv/pab_weight.sv
module pab_weight (
    input  logic              aclk,
    input  logic              aresetn,
    input  pab_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pab_pkg::in_pix_t  in_pix,
    output logic              out_valid,
    input  logic              out_ready,
    output pab_pkg::ops_t     out_ops
);
    import pab_pkg::*;

    logic        a_valid_reg;
    in_pix_t     a_pix_reg;
    logic [8:0]  a_w_reg;
    logic [15:0] a_p_reg;
    logic [8:0]  a_w_next;
    logic [15:0] a_p_next;

    logic        b_valid_reg;
    ops_t        b_ops_reg;
    ops_t        b_ops_next;

    logic        en_a;
    logic        en_b;

    logic [8:0]  k;
    logic [24:0] scaled_sum;
    logic [8:0]  m;
    logic [7:0]  src [4];
    logic [7:0]  dst [4];
    logic [7:0]  tint [3];

    // stage advance, a stage moves when it is empty or the next one moves
    assign en_b      = !b_valid_reg || out_ready;
    assign en_a      = !a_valid_reg || en_b;
    assign in_ready  = en_a;
    assign out_valid = b_valid_reg;
    assign out_ops   = b_ops_reg;

    // widened source alpha and source alpha times layer alpha
    assign a_w_next = {1'b0, in_pix.src_alpha} + {8'd0, in_pix.src_alpha[7]};
    assign a_p_next = in_pix.src_alpha * cfg.layer_alpha[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (en_a) a_valid_reg <= in_valid;
            if (en_b) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a && in_valid) begin
            a_pix_reg <= in_pix;
            a_w_reg   <= a_w_next;
            a_p_reg   <= a_p_next;
        end
        if (en_b && a_valid_reg) begin
            b_ops_reg <= b_ops_next;
        end
    end

    // layer-scaled weight: (p * 0x102) >> 16, always below 256
    assign scaled_sum = {1'b0, a_p_reg, 8'd0} + {8'd0, a_p_reg, 1'b0};
    assign m = cfg.layer_alpha[8] ? a_w_reg : {1'b0, scaled_sum[23:16]};
    assign k = WEIGHT_ONE - a_w_reg;

    assign src[CH_RED]   = a_pix_reg.src_red;
    assign src[CH_GREEN] = a_pix_reg.src_green;
    assign src[CH_BLUE]  = a_pix_reg.src_blue;
    assign src[CH_ALPHA] = a_pix_reg.src_alpha;
    assign dst[CH_RED]   = a_pix_reg.dst_red;
    assign dst[CH_GREEN] = a_pix_reg.dst_green;
    assign dst[CH_BLUE]  = a_pix_reg.dst_blue;
    assign dst[CH_ALPHA] = a_pix_reg.dst_alpha;
    assign tint[CH_RED]   = cfg.tint_red;
    assign tint[CH_GREEN] = cfg.tint_green;
    assign tint[CH_BLUE]  = cfg.tint_blue;

    // operand select per mode
    always_comb begin
        b_ops_next      = '0;
        b_ops_next.last = a_pix_reg.last_in;
        for (int i = 0; i < 3; i++) begin
            case (cfg.blend_mode) inside
                MODE_PREMULT, MODE_PREMULT_OPAQUE: begin
                    b_ops_next.lane[i].base = src[i];
                    b_ops_next.lane[i].wt   = k;
                    b_ops_next.lane[i].x    = $signed({1'b0, dst[i]});
                end
                MODE_TINT, MODE_TINT_OPAQUE: begin
                    b_ops_next.lane[i].base = dst[i];
                    b_ops_next.lane[i].wt   = a_w_reg;
                    b_ops_next.lane[i].x    = $signed({1'b0, tint[i]})
                                              - $signed({1'b0, dst[i]});
                end
                MODE_STRAIGHT: begin
                    b_ops_next.lane[i].base = dst[i];
                    b_ops_next.lane[i].wt   = m;
                    b_ops_next.lane[i].x    = $signed({1'b0, src[i]})
                                              - $signed({1'b0, dst[i]});
                end
                default: begin
                    b_ops_next.lane[i].base = dst[i];
                    b_ops_next.lane[i].wt   = '0;
                    b_ops_next.lane[i].x    = '0;
                end
            endcase
        end
        // alpha lane: source-over in modes 0 and 2, opaque in 1, 3 and 4, destination in 5..7
        case (cfg.blend_mode) inside
            MODE_PREMULT, MODE_TINT: begin
                b_ops_next.lane[CH_ALPHA].base = src[CH_ALPHA];
                b_ops_next.lane[CH_ALPHA].wt   = k;
                b_ops_next.lane[CH_ALPHA].x    = $signed({1'b0, dst[CH_ALPHA]});
            end
            MODE_PREMULT_OPAQUE, MODE_TINT_OPAQUE, MODE_STRAIGHT: begin
                b_ops_next.lane[CH_ALPHA].base = ALPHA_FULL;
                b_ops_next.lane[CH_ALPHA].wt   = '0;
                b_ops_next.lane[CH_ALPHA].x    = '0;
            end
            default: begin
                b_ops_next.lane[CH_ALPHA].base = dst[CH_ALPHA];
                b_ops_next.lane[CH_ALPHA].wt   = '0;
                b_ops_next.lane[CH_ALPHA].x    = '0;
            end
        endcase
    end

endmodule

FILE: sv/pab_mult.sv
module pab_mult (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pab_pkg::ops_t   in_ops,
    output logic            out_valid,
    input  logic            out_ready,
    output pab_pkg::prods_t out_prods
);
    import pab_pkg::*;

    logic   valid_reg;
    prods_t prods_reg;
    prods_t prods_next;
    logic   en;
    logic signed [18:0] full [4];

    assign en        = !valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_prods = prods_reg;

    // weight times signed operand x, one multiplier per lane
    always_comb begin
        prods_next      = '0;
        prods_next.last = in_ops.last;
        for (int i = 0; i < 4; i++) begin
            full[i] = $signed({1'b0, in_ops.lane[i].wt}) * in_ops.lane[i].x;
            prods_next.lane[i].base = in_ops.lane[i].base;
            prods_next.lane[i].prod = full[i][15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            prods_reg <= prods_next;
        end
    end

endmodule

FILE: sv/pab_out.sv
module pab_out (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pab_pkg::prods_t   in_prods,
    output logic              out_valid,
    input  logic              out_ready,
    output pab_pkg::out_pix_t out_pix
);
    import pab_pkg::*;

    logic     valid_reg;
    out_pix_t pix_reg;
    out_pix_t pix_next;
    logic     en;
    logic [7:0] sum [4];

    assign en        = !valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

    // base plus floor(prod / 256), wrapped to a byte
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum[i] = in_prods.lane[i].base + in_prods.lane[i].prod[15:8];
        end
        pix_next.out_red   = sum[CH_RED];
        pix_next.out_green = sum[CH_GREEN];
        pix_next.out_blue  = sum[CH_BLUE];
        pix_next.out_alpha = sum[CH_ALPHA];
        pix_next.last_out  = in_prods.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            pix_reg <= pix_next;
        end
    end

endmodule

FILE: sv/pab_checker.sv
module pab_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pab_pkg::in_pix_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input pab_pkg::out_pix_t m_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [2:0]        cfg_index,
    input logic [8:0]        cfg_data
);

    // a held result word keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input side only stalls when a full pipeline is blocked at the output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // registers are always writable
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind pixel_alpha_blender_top pab_checker u_pab_checker (.*);

FILE: tb/pixel_alpha_blender_top_tb.sv
module pixel_alpha_blender_top_tb;

    import pab_pkg::*;

    // blend mode codes with no defined operation, and register indexes with no register
    localparam logic [2:0] MODE_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNDEF_LAST  = 3'd7;
    localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;
    localparam int unsigned LAYER_SCALE     = 'h102;
    localparam int RANDOM_PHASES            = 14;
    localparam int WORDS_PER_PHASE          = 103;

    // mirror of the blender registers and the blended pixels still owed
    class blend_checker;
        out_pix_t   owed_pixels[$];
        logic [2:0] mode;
        logic [7:0] tint_r;
        logic [7:0] tint_g;
        logic [7:0] tint_b;
        logic [8:0] layer;
        int         errors;
        int         checked;

        function new();
            mode    = MODE_PREMULT;
            tint_r  = '0;
            tint_g  = '0;
            tint_b  = '0;
            layer   = WEIGHT_ONE;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [8:0] val);
            case (idx)
                REG_BLEND_MODE:  mode   = val[2:0];
                REG_TINT_RED:    tint_r = val[7:0];
                REG_TINT_GREEN:  tint_g = val[7:0];
                REG_TINT_BLUE:   tint_b = val[7:0];
                REG_LAYER_ALPHA: layer  = val;
                default: ;
            endcase
        endfunction

        // s + (k*d >> 8), wrapped to a byte
        function logic [7:0] over(logic [7:0] s, logic [7:0] d, int unsigned k);
            logic [31:0] t;
            t = s + ((k * d) >> 8);
            return t[7:0];
        endfunction

        // d + floor(a*(c - d)/256), wrapped to a byte
        function logic [7:0] mix(logic [7:0] d, logic [7:0] c, int unsigned a);
            int          p;
            logic [31:0] t;
            p = int'(a) * (int'(c) - int'(d));
            t = 32'(d) + 32'(p >>> 8);
            return t[7:0];
        endfunction

        function out_pix_t blend_pixel(in_pix_t px);
            int unsigned w;
            int unsigned k;
            int unsigned m;
            out_pix_t    o;
            w = px.src_alpha + (px.src_alpha >> 7);
            k = WEIGHT_ONE - w;
            o.out_red   = px.dst_red;
            o.out_green = px.dst_green;
            o.out_blue  = px.dst_blue;
            o.out_alpha = px.dst_alpha;
            o.last_out  = px.last_in;
            case (mode)
                MODE_PREMULT, MODE_PREMULT_OPAQUE: begin
                    o.out_red   = over(px.src_red, px.dst_red, k);
                    o.out_green = over(px.src_green, px.dst_green, k);
                    o.out_blue  = over(px.src_blue, px.dst_blue, k);
                    o.out_alpha = (mode == MODE_PREMULT) ?
                                  over(px.src_alpha, px.dst_alpha, k) : ALPHA_FULL;
                end
                MODE_TINT, MODE_TINT_OPAQUE: begin
                    o.out_red   = mix(px.dst_red, tint_r, w);
                    o.out_green = mix(px.dst_green, tint_g, w);
                    o.out_blue  = mix(px.dst_blue, tint_b, w);
                    o.out_alpha = (mode == MODE_TINT) ?
                                  over(px.src_alpha, px.dst_alpha, k) : ALPHA_FULL;
                end
                MODE_STRAIGHT: begin
                    m = (layer < WEIGHT_ONE) ?
                        (px.src_alpha * layer * LAYER_SCALE) >> 16 : w;
                    o.out_red   = mix(px.dst_red, px.src_red, m);
                    o.out_green = mix(px.dst_green, px.src_green, m);
                    o.out_blue  = mix(px.dst_blue, px.src_blue, m);
                    o.out_alpha = ALPHA_FULL;
                end
                default: ;
            endcase
            return o;
        endfunction

        function void note_pixel(in_pix_t px);
            owed_pixels.push_back(blend_pixel(px));
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(out_pix_t got);
            out_pix_t want;
            if (owed_pixels.size() == 0) begin
                $error("blended pixel arrived with none owed: %h", got);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            checked++;
            check_field("out_red", want.out_red, got.out_red);
            check_field("out_green", want.out_green, got.out_green);
            check_field("out_blue", want.out_blue, got.out_blue);
            check_field("out_alpha", want.out_alpha, got.out_alpha);
            check_field("last_out", 8'(want.last_out), 8'(got.last_out));
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_pix_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_pix_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = REG_BLEND_MODE;
    logic [8:0] cfg_data  = '0;

    blend_checker sb;
    int tx_max = 0;
    int rx_max = 0;
    int rx_hold = 0;
    int n_settings = 0;

    pixel_alpha_blender_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // result side: check each accepted word, then stall for a random count
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_pixel(m_data);
                rx_hold = $urandom_range(0, rx_max);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    // idle gap, then hold the word until the blender takes it
    task automatic send_pixel(input in_pix_t px);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_pixel(px);
    endtask

    // sender stops until every blended pixel is back and the pipe has emptied
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
    endtask

    // full register set, optionally followed by a write to an unused index
    task automatic configure(input logic [8:0] mode, input logic [8:0] tr,
                             input logic [8:0] tg, input logic [8:0] tb_val,
                             input logic [8:0] layer, input bit junk);
        settle();
        write_reg(REG_BLEND_MODE, mode);
        write_reg(REG_TINT_RED, tr);
        write_reg(REG_TINT_GREEN, tg);
        write_reg(REG_TINT_BLUE, tb_val);
        write_reg(REG_LAYER_ALPHA, layer);
        if (junk)
            write_reg(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), 9'($urandom));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic in_pix_t make_pixel(logic [7:0] sr, logic [7:0] sg, logic [7:0] sbl,
                                           logic [7:0] sa, logic [7:0] dr, logic [7:0] dg,
                                           logic [7:0] dbl, logic [7:0] da, logic last);
        in_pix_t px;
        px = '{sr, sg, sbl, sa, dr, dg, dbl, da, last};
        return px;
    endfunction

    // alpha leaning on the weight corners: 0, 127/128 around the widening step, 255
    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            3:       return 8'd127;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_pix_t rand_pixel();
        in_pix_t px;
        px = in_pix_t'({$urandom, $urandom, 1'b0});
        px.src_alpha = pick_alpha();
        px.dst_alpha = pick_alpha();
        px.last_in   = ($urandom_range(0, 7) == 0);
        return px;
    endfunction

    initial begin
        logic [8:0] mode_w;
        logic [8:0] layer_w;
        logic [7:0] tint_lvl;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        n_settings = 1;

        // reset settings: premultiplied over
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255, 1));
        send_pixel(make_pixel(255, 200, 17, 0, 255, 255, 255, 255, 0));
        send_pixel(make_pixel(40, 80, 120, 128, 250, 5, 128, 200, 0));
        send_pixel(make_pixel(40, 80, 120, 127, 250, 5, 128, 200, 1));
        send_pixel(make_pixel(255, 128, 1, 1, 254, 255, 255, 255, 0));

        configure(MODE_PREMULT_OPAQUE, 0, 0, 0, WEIGHT_ONE, 0);
        send_pixel(make_pixel(10, 20, 30, 64, 200, 100, 50, 0, 0));
        send_pixel(make_pixel(255, 255, 255, 0, 255, 255, 255, 17, 1));

        configure(MODE_TINT, 255, 0, 128, WEIGHT_ONE, 0);
        send_pixel(make_pixel(0, 0, 0, 255, 0, 0, 0, 255, 0));
        send_pixel(make_pixel(0, 0, 0, 128, 255, 255, 255, 100, 0));
        send_pixel(make_pixel(9, 9, 9, 0, 77, 200, 3, 255, 1));

        configure(MODE_TINT_OPAQUE, 0, 255, 37, WEIGHT_ONE, 0);
        send_pixel(make_pixel(0, 0, 0, 200, 255, 0, 37, 0, 0));
        send_pixel(make_pixel(0, 0, 0, 1, 128, 128, 128, 9, 1));

        configure(MODE_STRAIGHT, 0, 0, 0, WEIGHT_ONE, 0);
        send_pixel(make_pixel(0, 10, 255, 128, 255, 200, 0, 0, 0));
        send_pixel(make_pixel(255, 255, 0, 255, 0, 0, 255, 40, 1));

        // layer alpha at zero, just below one, and above one
        configure(MODE_STRAIGHT, 0, 0, 0, 0, 0);
        send_pixel(make_pixel(255, 0, 200, 255, 0, 255, 10, 0, 0));
        configure(MODE_STRAIGHT, 0, 0, 0, 255, 0);
        send_pixel(make_pixel(255, 0, 200, 255, 0, 255, 10, 0, 0));
        send_pixel(make_pixel(3, 250, 90, 100, 200, 1, 91, 0, 1));
        configure(MODE_STRAIGHT, 0, 0, 0, 300, 0);
        send_pixel(make_pixel(255, 0, 200, 200, 0, 255, 10, 0, 0));

        // undefined modes pass the destination through
        configure(MODE_UNDEF_FIRST, 255, 255, 255, 0, 0);
        send_pixel(make_pixel(1, 2, 3, 200, 44, 55, 66, 77, 1));
        configure(MODE_UNDEF_LAST, 0, 0, 0, WEIGHT_ONE, 0);
        send_pixel(make_pixel(255, 255, 255, 255, 0, 128, 255, 1, 0));

        // writes to unused indexes must leave the registers alone
        configure(MODE_PREMULT, 7, 7, 7, WEIGHT_ONE, 1);
        send_pixel(make_pixel(100, 100, 100, 100, 100, 100, 100, 100, 0));

        // random phases, each under its own settings and idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 10)
                mode_w = 9'(ph % 5);
            else if ($urandom_range(0, 5) == 5)
                mode_w = 9'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
            else
                mode_w = 9'($urandom_range(MODE_PREMULT, MODE_STRAIGHT));
            mode_w[8:3] = 6'($urandom);
            case (ph % 6)
                0:       layer_w = 9'd0;
                1:       layer_w = 9'd1;
                2:       layer_w = 9'd255;
                3:       layer_w = WEIGHT_ONE;
                4:       layer_w = 9'd511;
                default: layer_w = 9'($urandom);
            endcase
            tint_lvl = (ph % 4 == 0) ? 8'd0 : 8'd255;
            if (ph % 4 >= 2)
                configure(mode_w, 9'($urandom), 9'($urandom), 9'($urandom), layer_w,
                          ph % 5 == 2);
            else
                configure(mode_w, {1'($urandom), tint_lvl}, {1'b0, tint_lvl},
                          {1'($urandom), tint_lvl}, layer_w, ph % 5 == 2);
            tx_max = (ph % 3 == 0) ? 0 : 10;
            rx_max = (ph % 4 == 1) ? 0 : 10;
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (i == WORDS_PER_PHASE / 2 && ph % 2 == 1)
                    settle();
                send_pixel(rand_pixel());
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("checked %0d blended pixels under %0d register settings", sb.checked,
                 n_settings);
        $display("covered all blend modes, pass-through modes, layer alpha extremes and stalls");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pab_pkg.sv
sv/pab_weight.sv
sv/pab_mult.sv
sv/pab_out.sv
sv/pixel_alpha_blender_top.sv
sv/pab_checker.sv
tb/pixel_alpha_blender_top_tb.sv
